// ===== rtl/core/kdlp_pkg.sv =====
`default_nettype none

package kdlp_pkg;

	// Key group width, fixed by the field widths of the channels
	localparam int unsigned KeyBits = 4;
	localparam int unsigned CfgW    = 8;
	localparam int unsigned CfgIdxW = 2;

	// Configuration register indexes
	typedef enum logic [CfgIdxW-1:0] {
		CFG_COUNT_MAX       = 2'd0,
		CFG_REPEAT_RELOAD   = 2'd1,
		CFG_SHORT_THRESHOLD = 2'd2,
		CFG_MENU_MASK       = 2'd3
	} cfg_idx_t;

	// Item kinds
	localparam logic KIND_SCAN  = 1'b0;
	localparam logic KIND_FETCH = 1'b1;

	// Reset values of the configuration registers
	localparam logic [7:0]         CountMaxRst       = 8'd200;
	localparam logic [7:0]         RepeatReloadRst   = 8'd180;
	localparam logic [7:0]         ShortThresholdRst = 8'd4;
	localparam logic [KeyBits-1:0] MenuMaskRst       = '0;

	typedef struct packed {
		logic               kind;
		logic [KeyBits-1:0] key_lines;
	} kdlp_in_t;

	typedef struct packed {
		logic [KeyBits-1:0] key_code;
		logic               long_press;
	} kdlp_out_t;

	typedef struct packed {
		logic [7:0]         count_max;
		logic [7:0]         repeat_reload;
		logic [7:0]         short_threshold;
		logic [KeyBits-1:0] menu_mask;
	} kdlp_cfg_t;

endpackage

`default_nettype wire

// ===== rtl/core/kdlp_engine.sv =====
`default_nettype none

module kdlp_engine (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 fire,
	input  kdlp_pkg::kdlp_in_t  item,
	input  kdlp_pkg::kdlp_cfg_t cfg,
	output kdlp_pkg::kdlp_out_t result
);
	import kdlp_pkg::*;

	logic [KeyBits-1:0] held_code_q;
	logic [7:0]         hold_count_q;
	logic               pending_q;
	logic               long_q;
	logic               reported_q;

	logic [KeyBits-1:0] held_code_d;
	logic [7:0]         hold_count_d;
	logic               pending_d;
	logic               long_d;
	logic               reported_d;

	logic [KeyBits-1:0] pressed;

	assign pressed = ~item.key_lines;

	// Present the pending press, or zero when nothing waits
	always_comb begin
		result.key_code   = pending_q ? held_code_q : '0;
		result.long_press = pending_q & long_q;
	end

	// Work out the state update for the current transaction
	always_comb begin
		held_code_d  = held_code_q;
		hold_count_d = hold_count_q;
		pending_d    = pending_q;
		long_d       = long_q;
		reported_d   = reported_q;
		if (item.kind == KIND_FETCH) begin
			if (pending_q) begin
				pending_d  = 1'b0;
				reported_d = 1'b1;
			end
		end else if (pressed == held_code_q) begin
			if (pressed != '0) begin
				if (hold_count_q == cfg.count_max) begin
					// long press: repeat unless a menu key is down
					if ((pressed & cfg.menu_mask) == '0)
						hold_count_d = cfg.repeat_reload;
					long_d    = 1'b1;
					pending_d = 1'b1;
				end else begin
					hold_count_d = hold_count_q + 8'd1;
				end
			end
		end else if (pressed == '0 && held_code_q != '0 &&
			hold_count_q > cfg.short_threshold && !reported_q && !long_q) begin
			// short press released
			pending_d = 1'b1;
		end else begin
			held_code_d  = pressed;
			hold_count_d = '0;
			pending_d    = 1'b0;
			long_d       = 1'b0;
			reported_d   = 1'b0;
		end
	end

	// Commit the update when a transaction leaves the input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_code_q  <= '0;
			hold_count_q <= '0;
			pending_q    <= 1'b0;
			long_q       <= 1'b0;
			reported_q   <= 1'b0;
		end else if (fire) begin
			held_code_q  <= held_code_d;
			hold_count_q <= hold_count_d;
			pending_q    <= pending_d;
			long_q       <= long_d;
			reported_q   <= reported_d;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/key_debounce_long_press.sv =====
// A fetch is held in the input stage and loaded into the output register once
//   that register is free to take it; a scan tick gives no result.
// Throughput: one transaction per cycle unless a fetch waits on a full output
//   register; the state update from the input stage is combinational.
// Reset (arst_n low): key state and marks cleared, registers to defaults.
`default_nettype none

module key_debounce_long_press (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       cfg_we,
	input  wire [kdlp_pkg::CfgIdxW-1:0] cfg_idx,
	input  wire [kdlp_pkg::CfgW-1:0]  cfg_wdata,
	input  wire                       key_valid,
	output logic                      key_ready,
	input  kdlp_pkg::kdlp_in_t        key_item,
	output logic                      rsp_valid,
	input  wire                       rsp_ready,
	output kdlp_pkg::kdlp_out_t       rsp_item
);
	import kdlp_pkg::*;

	kdlp_cfg_t  cfg_q;
	kdlp_in_t   item_s1;
	logic       valid_s1;
	logic       advance_s1;
	logic       rsp_free;
	kdlp_out_t  result;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.count_max       <= CountMaxRst;
			cfg_q.repeat_reload   <= RepeatReloadRst;
			cfg_q.short_threshold <= ShortThresholdRst;
			cfg_q.menu_mask       <= MenuMaskRst;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_idx))
				CFG_COUNT_MAX:       cfg_q.count_max       <= cfg_wdata;
				CFG_REPEAT_RELOAD:   cfg_q.repeat_reload   <= cfg_wdata;
				CFG_SHORT_THRESHOLD: cfg_q.short_threshold <= cfg_wdata;
				CFG_MENU_MASK:       cfg_q.menu_mask       <= cfg_wdata[KeyBits-1:0];
				default: ;
			endcase
		end
	end

	// Stage 1 drains when it is a scan or the output register has room
	assign rsp_free   = !rsp_valid || rsp_ready;
	assign advance_s1 = valid_s1 && (item_s1.kind == KIND_SCAN || rsp_free);
	assign key_ready  = !valid_s1 || advance_s1;

	// Hold the accepted transaction in the input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (key_ready) begin
			valid_s1 <= key_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (key_ready && key_valid)
			item_s1 <= key_item;
	end

	kdlp_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (advance_s1),
		.item   (item_s1),
		.cfg    (cfg_q),
		.result (result)
	);

	// Load fetch results, drop them once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid <= 1'b0;
		end else if (rsp_free) begin
			rsp_valid <= advance_s1 && item_s1.kind == KIND_FETCH;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_free && advance_s1 && item_s1.kind == KIND_FETCH)
			rsp_item <= result;
	end

endmodule

`default_nettype wire

// ===== tb/tb_key_debounce_long_press.sv =====
`timescale 1ns / 1ps

import kdlp_pkg::*;

// Tracks the key state and holds the fetch answers that are still due
class key_report_scoreboard;
	logic [7:0]         count_max;
	logic [7:0]         repeat_reload;
	logic [7:0]         short_threshold;
	logic [KeyBits-1:0] menu_mask;

	logic [KeyBits-1:0] held_code;
	logic [7:0]         hold_count;
	bit                 pending_mark;
	bit                 long_mark;
	bit                 reported_mark;

	kdlp_out_t due_reports[$];

	int fail_count;
	int items_seen;
	int fetches_seen;
	int keys_reported;
	int long_reported;

	function new();
		count_max       = CountMaxRst;
		repeat_reload   = RepeatReloadRst;
		short_threshold = ShortThresholdRst;
		menu_mask       = MenuMaskRst;
		held_code       = '0;
		hold_count      = '0;
		pending_mark    = 1'b0;
		long_mark       = 1'b0;
		reported_mark   = 1'b0;
	endfunction

	task report_mismatch(input string msg);
		$display("MISMATCH at %0t ns: %s", $time, msg);
		fail_count++;
	endtask

	function void write_reg(input cfg_idx_t idx, input logic [7:0] val);
		case (idx)
			CFG_COUNT_MAX:       count_max = val;
			CFG_REPEAT_RELOAD:   repeat_reload = val;
			CFG_SHORT_THRESHOLD: short_threshold = val;
			CFG_MENU_MASK:       menu_mask = val[KeyBits-1:0];
			default:             ;
		endcase
	endfunction

	// Advance the debounce state on one scan tick
	function void scan_tick(input logic [KeyBits-1:0] lines);
		logic [KeyBits-1:0] pressed;
		pressed = ~lines;
		if (pressed == held_code) begin
			if (pressed != '0) begin
				if (hold_count == count_max) begin
					if ((pressed & menu_mask) == '0) begin
						hold_count = repeat_reload;
					end
					long_mark    = 1'b1;
					pending_mark = 1'b1;
				end else begin
					hold_count = hold_count + 8'd1;
				end
			end
		end else if (pressed == '0 && held_code != '0 && hold_count > short_threshold &&
				!reported_mark && !long_mark) begin
			pending_mark = 1'b1;
		end else begin
			held_code     = pressed;
			hold_count    = '0;
			pending_mark  = 1'b0;
			long_mark     = 1'b0;
			reported_mark = 1'b0;
		end
	endfunction

	// Note an accepted input transaction; a fetch queues its answer
	function void note_item(input kdlp_in_t it);
		kdlp_out_t ans;
		items_seen++;
		if (it.kind == KIND_SCAN) begin
			scan_tick(it.key_lines);
		end else begin
			fetches_seen++;
			ans = '0;
			if (pending_mark) begin
				ans.key_code   = held_code;
				ans.long_press = long_mark;
				pending_mark   = 1'b0;
				reported_mark  = 1'b1;
				keys_reported++;
				if (long_mark) begin
					long_reported++;
				end
			end
			due_reports.push_back(ans);
		end
	endfunction

	// Compare one accepted result with the oldest answer due
	task check_report(input kdlp_out_t got);
		kdlp_out_t want;
		if (due_reports.size() == 0) begin
			report_mismatch($sformatf("result code=%h long=%b with none expected",
				got.key_code, got.long_press));
		end else begin
			want = due_reports.pop_front();
			if (got.key_code !== want.key_code) begin
				report_mismatch($sformatf("key_code got %h want %h",
					got.key_code, want.key_code));
			end
			if (got.long_press !== want.long_press) begin
				report_mismatch($sformatf("long_press got %b want %b",
					got.long_press, want.long_press));
			end
		end
	endtask

	function int reports_left();
		return due_reports.size();
	endfunction
endclass

module tb_key_debounce_long_press;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_we = 1'b0;
	logic [1:0]         cfg_idx = '0;
	logic [7:0]         cfg_wdata = '0;
	logic               key_valid = 1'b0;
	logic               key_ready;
	kdlp_in_t           key_item = '0;
	logic               rsp_valid;
	logic               rsp_ready = 1'b0;
	kdlp_out_t          rsp_item;

	key_report_scoreboard sb = new();

	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	int rx_hold_cycles = 0;
	int items_sent = 0;
	int settings_run = 0;

	key_debounce_long_press i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.key_valid (key_valid),
		.key_ready (key_ready),
		.key_item  (key_item),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp_item  (rsp_item)
	);

	// 4 ns clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Drive the result ready: long hold-off first, else random stalls
	always @(negedge clk) begin
		if (rx_hold_cycles > 0) begin
			rsp_ready <= 1'b0;
			rx_hold_cycles <= rx_hold_cycles - 1;
		end else begin
			rsp_ready <= ($urandom_range(99, 0) >= rx_idle_pct);
		end
	end

	// Observe both channels at the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (key_valid && key_ready) begin
				sb.note_item(key_item);
			end
			if (rsp_valid && rsp_ready) begin
				sb.check_report(rsp_item);
			end
		end
	end

	// Offer one input transaction and hold it until accepted
	task automatic send_item(input logic kind, input logic [KeyBits-1:0] lines);
		kdlp_in_t it;
		it.kind      = kind;
		it.key_lines = lines;
		while ($urandom_range(99, 0) < tx_idle_pct) begin
			@(negedge clk);
			key_valid <= 1'b0;
		end
		@(negedge clk);
		key_valid <= 1'b1;
		key_item  <= it;
		do @(posedge clk); while (!key_ready);
		items_sent++;
	endtask

	task automatic scan_lines(input logic [KeyBits-1:0] lines);
		send_item(KIND_SCAN, lines);
	endtask

	task automatic fetch_key();
		send_item(KIND_FETCH, KeyBits'($urandom_range(15, 0)));
	endtask

	// Stop sending and wait until every fetch has been answered
	task automatic drain();
		@(negedge clk);
		key_valid <= 1'b0;
		while (sb.reports_left() != 0) begin
			@(posedge clk);
		end
		repeat (4) @(posedge clk);
	endtask

	task automatic write_cfg(input cfg_idx_t idx, input logic [7:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= val;
		sb.write_reg(idx, val);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Move to a new register setting once the block is idle
	task automatic apply_setting(input logic [7:0] cmax, input logic [7:0] reload,
			input logic [7:0] thr, input logic [7:0] menu, input int tx_pct, input int rx_pct);
		drain();
		write_cfg(CFG_COUNT_MAX, cmax);
		write_cfg(CFG_REPEAT_RELOAD, reload);
		write_cfg(CFG_SHORT_THRESHOLD, thr);
		write_cfg(CFG_MENU_MASK, menu);
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
		settings_run++;
	endtask

	// Hold one key code for a while, release it, and usually fetch
	task automatic press_sequence(input int max_hold);
		logic [KeyBits-1:0] code;
		int ticks;
		int lim;
		code = KeyBits'($urandom_range(15, 1));
		lim  = int'(sb.short_threshold) + 3;
		if (lim > max_hold) begin
			lim = max_hold;
		end
		if ($urandom_range(99, 0) < 60) begin
			ticks = $urandom_range(lim, 0);
		end else begin
			ticks = $urandom_range(max_hold, 0);
		end
		for (int i = 0; i <= ticks; i++) begin
			scan_lines(~code);
			if ($urandom_range(99, 0) < 8) begin
				fetch_key();
			end
		end
		// release to no key, or jump straight to another code
		if ($urandom_range(99, 0) < 80) begin
			scan_lines('1);
			if ($urandom_range(99, 0) < 40) begin
				scan_lines('1);
			end
		end else begin
			scan_lines(KeyBits'($urandom_range(15, 0)));
		end
		if ($urandom_range(99, 0) < 75) begin
			fetch_key();
		end
		if ($urandom_range(99, 0) < 20) begin
			fetch_key();
		end
	endtask

	// Mostly well-formed presses, the rest random transactions
	task automatic run_random(input int n_items, input int max_hold);
		int first;
		first = items_sent;
		while (items_sent - first < n_items) begin
			if ($urandom_range(99, 0) < 75) begin
				press_sequence(max_hold);
			end else begin
				repeat ($urandom_range(4, 1)) begin
					send_item(1'($urandom_range(1, 0)), KeyBits'($urandom_range(15, 0)));
				end
			end
		end
	endtask

	// Timeout
	initial begin
		#2_000_000;
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: short count, reload below max, bit 3 is a menu key
		apply_setting(8'd3, 8'd1, 8'd1, 8'h8, 10, 49);
		fetch_key();
		repeat (3) scan_lines(4'h0);
		scan_lines(4'hF);
		fetch_key();
		scan_lines(4'hF);
		repeat (5) scan_lines(4'h7);
		fetch_key();
		fetch_key();
		repeat (5) scan_lines(4'hE);
		fetch_key();
		repeat (3) scan_lines(4'hD);
		repeat (2) scan_lines(4'hF);
		fetch_key();
		scan_lines(4'hF);
		fetch_key();
		run_random(180, 15);

		// All registers at their low end
		apply_setting(8'd0, 8'd0, 8'd0, 8'h0, 10, 49);
		run_random(150, 6);

		// All registers at their high end, every key a menu key
		apply_setting(8'd255, 8'd255, 8'd255, 8'hF, 49, 10);
		run_random(260, 270);

		// Reload above the max: the count wraps through zero
		apply_setting(8'd2, 8'd250, 8'd0, 8'h0, 49, 10);
		run_random(150, 20);

		// Fill the block while results are held off, then let it drain
		apply_setting(8'd5, 8'd2, 8'd1, 8'h5, 0, 0);
		rx_hold_cycles = 120;
		repeat (40) fetch_key();
		drain();
		run_random(180, 25);

		// Back to the reset values
		apply_setting(CountMaxRst, RepeatReloadRst, ShortThresholdRst, 8'(MenuMaskRst), 0, 0);
		run_random(300, 230);

		apply_setting(8'd7, 8'd9, 8'd2, 8'h3, 0, 0);
		run_random(150, 30);

		drain();
		repeat (8) @(posedge clk);
		if (sb.reports_left() != 0) begin
			sb.report_mismatch($sformatf("%0d fetch results never arrived", sb.reports_left()));
		end
		$display("Covered %0d transactions over %0d register settings, %0d of them fetches.",
			sb.items_seen, settings_run, sb.fetches_seen);
		$display("Fetches returned %0d key presses, %0d of them long.",
			sb.keys_reported, sb.long_reported);
		if (sb.fail_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
